>>> rtl/pcu_pkg.sv
// ----------------------------------------------------------------------------
// pcu_pkg
// shared types and command codes for the correlation unit
// ----------------------------------------------------------------------------
package pcu_pkg;

    localparam logic [3:0] OP_IDLE   = 4'd0;
    localparam logic [3:0] OP_MLOAD  = 4'd1;
    localparam logic [3:0] OP_MSTEP  = 4'd2;
    localparam logic [3:0] OP_MSTORE = 4'd3;
    localparam logic [3:0] OP_SQLOAD = 4'd4;
    localparam logic [3:0] OP_SQSTEP = 4'd5;
    localparam logic [3:0] OP_DVLOAD = 4'd6;
    localparam logic [3:0] OP_DVSTEP = 4'd7;
    localparam logic [3:0] OP_FIN    = 4'd8;

    // multiply sequence
    localparam logic [2:0] SEL_N_SQA  = 3'd0;
    localparam logic [2:0] SEL_MA_MA  = 3'd1;
    localparam logic [2:0] SEL_N_SQB  = 3'd2;
    localparam logic [2:0] SEL_MB_MB  = 3'd3;
    localparam logic [2:0] SEL_N_X    = 3'd4;
    localparam logic [2:0] SEL_A_B    = 3'd5;
    localparam logic [2:0] SEL_XX_YY  = 3'd6;

    localparam int MUL_STEPS = 64;
    localparam int SQRT_STEPS = 64;
    localparam int DIV_STEPS = 14;
    localparam logic [16:0] COEF_MAX = 17'd16384;

    typedef struct packed {
        logic       acc;
        logic [3:0] op;
        logic [2:0] sel;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

>>> rtl/pcu_ctrl.sv
// ----------------------------------------------------------------------------
// pcu_ctrl
// sequencer: accumulate, six multiplies, product, square root, divide
// ----------------------------------------------------------------------------
module pcu_ctrl
    import pcu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  is_last,
    output logic  in_stall,
    output cmd_t  cmd,
    input  stat_t stat
);

    localparam logic [3:0] S_ACC = 4'd0;
    localparam logic [3:0] S_MLD = 4'd1;
    localparam logic [3:0] S_MST = 4'd2;
    localparam logic [3:0] S_MSV = 4'd3;
    localparam logic [3:0] S_SQL = 4'd4;
    localparam logic [3:0] S_SQS = 4'd5;
    localparam logic [3:0] S_DVL = 4'd6;
    localparam logic [3:0] S_DVS = 4'd7;
    localparam logic [3:0] S_FIN = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [2:0] sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACC;
            cnt_reg   <= '0;
            sel_reg   <= SEL_N_SQA;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        in_stall   = 1'b1;
        cmd.acc    = 1'b0;
        cmd.op     = OP_IDLE;
        cmd.sel    = sel_reg;
        case (state_reg)
            S_ACC:
            begin
                in_stall = 1'b0;
                cmd.acc  = in_valid;
                if (in_valid && is_last)
                begin
                    sel_next   = SEL_N_SQA;
                    state_next = S_MLD;
                end
            end
            S_MLD:
            begin
                cmd.op     = OP_MLOAD;
                cnt_next   = '0;
                state_next = S_MST;
            end
            S_MST:
            begin
                cmd.op   = OP_MSTEP;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(MUL_STEPS - 1))
                    state_next = S_MSV;
            end
            S_MSV:
            begin
                cmd.op = OP_MSTORE;
                if (sel_reg == SEL_XX_YY)
                    state_next = S_SQL;
                else
                begin
                    sel_next   = sel_reg + 3'd1;
                    state_next = S_MLD;
                end
            end
            S_SQL:
            begin
                cmd.op     = OP_SQLOAD;
                cnt_next   = '0;
                state_next = S_SQS;
            end
            S_SQS:
            begin
                cmd.op   = OP_SQSTEP;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(SQRT_STEPS - 1))
                    state_next = S_DVL;
            end
            S_DVL:
            begin
                cmd.op     = OP_DVLOAD;
                cnt_next   = '0;
                state_next = S_DVS;
            end
            S_DVS:
            begin
                cmd.op   = OP_DVSTEP;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_STEPS - 1))
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_FIN;
                    state_next = S_ACC;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_fin_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_FIN |-> stat.out_free)
        else $error("result issued while output register busy");
    a_last_starts_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC && in_valid && is_last) |=> state_reg == S_MLD)
        else $error("last transaction did not start the sequence");
    a_stall_outside_acc: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_ACC |-> in_stall)
        else $error("input taken during computation");
`endif

endmodule

>>> rtl/pcu_dp.sv
// ----------------------------------------------------------------------------
// pcu_dp
// accumulators, shift-add multiplier, digit square root, divider, output
// ----------------------------------------------------------------------------
module pcu_dp
    import pcu_pkg::*;
#(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [15:0] sample_a,
    input  logic [15:0] sample_b,
    output logic [15:0] coefficient,
    output logic        degenerate,
    output logic        too_many,
    output logic        out_valid,
    input  logic        out_stall
);

    localparam int W  = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = W + CW;
    localparam int QW = 2 * W + CW;

    logic signed [W-1:0]     a_w, b_w;
    logic signed [2*W-1:0]   aa, bb, ab;
    logic [CW-1:0]           cnt_reg;
    logic signed [SW-1:0]    sa_reg, sb_reg;
    logic signed [QW-1:0]    sqa_reg, sqb_reg, sx_reg;
    logic                    ovf_reg;

    logic [127:0] mcand_reg, prod_reg, x_reg;
    logic [63:0]  mplier_reg, t_reg, sxx_reg, syy_reg, sxy_reg, root_reg, dvr;
    logic [63:0]  op_a, op_b, sa64, sb64, ma64, mb64, qmag;
    logic [67:0]  srem_reg, rem_t, trial;
    logic [64:0]  drem_reg, drem_sh, dload;
    logic [16:0]  res_reg, res_rnd, res_cl;
    logic         neg_reg;
    logic [15:0]  coef_reg;
    logic         degen_reg, many_reg, ov_reg;

    assign a_w = sample_a[W-1:0];
    assign b_w = sample_b[W-1:0];
    assign aa  = a_w * a_w;
    assign bb  = b_w * b_w;
    assign ab  = a_w * b_w;

    assign sa64 = 64'(sa_reg);
    assign sb64 = 64'(sb_reg);
    assign ma64 = sa64[63] ? (64'd0 - sa64) : sa64;
    assign mb64 = sb64[63] ? (64'd0 - sb64) : sb64;

    always_comb
    begin
        case (cmd.sel)
            SEL_N_SQA: begin op_a = 64'(cnt_reg); op_b = 64'(sqa_reg); end
            SEL_MA_MA: begin op_a = ma64;         op_b = ma64;         end
            SEL_N_SQB: begin op_a = 64'(cnt_reg); op_b = 64'(sqb_reg); end
            SEL_MB_MB: begin op_a = mb64;         op_b = mb64;         end
            SEL_N_X:   begin op_a = 64'(cnt_reg); op_b = 64'(sx_reg);  end
            SEL_A_B:   begin op_a = sa64;         op_b = sb64;         end
            SEL_XX_YY: begin op_a = sxx_reg;      op_b = syy_reg;      end
            default:   begin op_a = '0;           op_b = '0;           end
        endcase
    end

    // divisor: root, forced to one when zero
    assign dvr = (root_reg == 64'd0) ? 64'd1 : root_reg;

    assign rem_t   = {srem_reg[65:0], x_reg[127:126]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign qmag    = sxy_reg[63] ? (64'd0 - sxy_reg) : sxy_reg;
    assign dload   = ({1'b0, qmag} >= {1'b0, dvr}) ? ({1'b0, qmag} - {1'b0, dvr})
                                                   : {1'b0, qmag};
    assign drem_sh = {drem_reg[63:0], 1'b0};
    assign res_rnd = res_reg + 17'((drem_reg >= ({1'b0, dvr} - drem_reg)) ? 1 : 0);
    assign res_cl  = (res_rnd > COEF_MAX) ? COEF_MAX : res_rnd;

    // accumulators and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sa_reg  <= '0;
            sb_reg  <= '0;
            sqa_reg <= '0;
            sqb_reg <= '0;
            sx_reg  <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.op == OP_FIN)
        begin
            cnt_reg <= '0;
            sa_reg  <= '0;
            sb_reg  <= '0;
            sqa_reg <= '0;
            sqb_reg <= '0;
            sx_reg  <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.acc)
        begin
            if (32'(cnt_reg) < 32'(MAX_SAMPLES))
            begin
                cnt_reg <= cnt_reg + CW'(1);
                sa_reg  <= sa_reg + SW'(a_w);
                sb_reg  <= sb_reg + SW'(b_w);
                sqa_reg <= sqa_reg + QW'(aa);
                sqb_reg <= sqb_reg + QW'(bb);
                sx_reg  <= sx_reg + QW'(ab);
            end
            else
                ovf_reg <= 1'b1;
        end
    end

    // arithmetic sequence
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_MLOAD:
            begin
                mcand_reg  <= {64'd0, op_a};
                mplier_reg <= op_b;
                prod_reg   <= '0;
            end
            OP_MSTEP:
            begin
                if (mplier_reg[0])
                    prod_reg <= prod_reg + mcand_reg;
                mcand_reg  <= {mcand_reg[126:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[63:1]};
            end
            OP_MSTORE:
            begin
                case (cmd.sel)
                    SEL_MA_MA: sxx_reg <= t_reg - prod_reg[63:0];
                    SEL_MB_MB: syy_reg <= t_reg - prod_reg[63:0];
                    SEL_A_B:   sxy_reg <= t_reg - prod_reg[63:0];
                    default:   t_reg   <= prod_reg[63:0];
                endcase
            end
            OP_SQLOAD:
            begin
                x_reg    <= prod_reg;
                root_reg <= '0;
                srem_reg <= '0;
            end
            OP_SQSTEP:
            begin
                x_reg <= {x_reg[125:0], 2'b00};
                if (rem_t >= trial)
                begin
                    srem_reg <= rem_t - trial;
                    root_reg <= {root_reg[62:0], 1'b1};
                end
                else
                begin
                    srem_reg <= rem_t;
                    root_reg <= {root_reg[62:0], 1'b0};
                end
            end
            OP_DVLOAD:
            begin
                neg_reg <= sxy_reg[63];
                res_reg <= ({1'b0, qmag} >= {1'b0, dvr}) ? 17'd1 : 17'd0;
                if (dload >= {1'b0, dvr})
                    drem_reg <= {1'b0, dvr} - 65'd1;
                else
                    drem_reg <= dload;
            end
            OP_DVSTEP:
            begin
                if (drem_sh >= {1'b0, dvr})
                begin
                    drem_reg <= drem_sh - {1'b0, dvr};
                    res_reg  <= {res_reg[15:0], 1'b1};
                end
                else
                begin
                    drem_reg <= drem_sh;
                    res_reg  <= {res_reg[15:0], 1'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.op == OP_FIN)
            ov_reg <= 1'b1;
        else if (!out_stall)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_FIN)
        begin
            degen_reg <= (sxx_reg == 64'd0) || (syy_reg == 64'd0);
            many_reg  <= ovf_reg;
            if ((sxx_reg == 64'd0) || (syy_reg == 64'd0))
                coef_reg <= '0;
            else
                coef_reg <= neg_reg ? (16'd0 - res_cl[15:0]) : res_cl[15:0];
        end
    end

    assign stat.out_free = !ov_reg || !out_stall;
    assign out_valid     = ov_reg;
    assign coefficient   = coef_reg;
    assign degenerate    = degen_reg;
    assign too_many      = many_reg;

`ifndef SYNTHESIS
    a_fin_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_FIN |=> out_valid)
        else $error("result not presented");
    a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_FIN |=> (cnt_reg == '0 && !ovf_reg))
        else $error("accumulators not cleared");
    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.op) == OP_DVSTEP |-> drem_reg < {1'b0, dvr})
        else $error("divider remainder out of range");
`endif

endmodule

>>> rtl/pearson_correlation_unit_core.sv
// ----------------------------------------------------------------------------
// pearson_correlation_unit_core
// correlation coefficient of paired samples, Q2.14 result per data set
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid/in_stall    sample_a, sample_b, is_last
//  out      output     out_valid/out_stall  coefficient, degenerate, too_many
//
//  one pair per cycle while accumulating
//  a last pair starts a sequence (seven shift-add multiplies, a square root,
//  a divide, a finishing step) set by the shared serial units; the finishing
//  step waits while a held result is stalled
//  reset clears all accumulators, the overflow flag and the output valid bit
//  input stalls during the sequence; the result waits in its register
//  while the next data set accumulates
module pearson_correlation_unit_core
    import pcu_pkg::*;
#(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] sample_a,
    input  logic [15:0] sample_b,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] coefficient,
    output logic        degenerate,
    output logic        too_many
);

    cmd_t  cmd;
    stat_t stat;

    pcu_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .is_last  (is_last),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    pcu_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .sample_a    (sample_a),
        .sample_b    (sample_b),
        .coefficient (coefficient),
        .degenerate  (degenerate),
        .too_many    (too_many),
        .out_valid   (out_valid),
        .out_stall   (out_stall)
    );

endmodule
